@@ src/wac_pkg.sv @@
// shared types, constants and helpers for the weekday alarm clock
// no dependencies; imported by every module of the block
`default_nettype none

package wac_pkg;

    // ticks that make up one second
    localparam int TICKS_PER_SECOND = 1000;
    localparam int MS_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

    // command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_SYNC  = 2'd1;
    localparam logic [1:0] REQ_ARM   = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // register indexes on the config port
    localparam logic [1:0] REG_ALARM_HOUR   = 2'd0;
    localparam logic [1:0] REG_ALARM_MINUTE = 2'd1;
    localparam logic [1:0] REG_REPEAT_MASK  = 2'd2;
    localparam logic [1:0] REG_ALARM_ACTION = 2'd3;

    // classified command, sync fields already reduced
    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } cmd_t;

    // alarm configuration
    typedef struct packed {
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic [6:0] repeat_mask;
        logic [7:0] alarm_action;
    } cfg_t;

    // 8-bit value modulo 24 by restoring subtraction
    function automatic logic [4:0] mod24(input logic [7:0] x);
        logic [7:0] r;
        r = x;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        return r[4:0];
    endfunction

    // 8-bit value modulo 60
    function automatic logic [5:0] mod60(input logic [7:0] x);
        logic [7:0] r;
        r = x;
        if (r >= 8'd240) r = r - 8'd240;
        if (r >= 8'd120) r = r - 8'd120;
        if (r >= 8'd60)  r = r - 8'd60;
        return r[5:0];
    endfunction

    // 8-bit value modulo 7
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [7:0] r;
        r = x;
        if (r >= 8'd224) r = r - 8'd224;
        if (r >= 8'd112) r = r - 8'd112;
        if (r >= 8'd56)  r = r - 8'd56;
        if (r >= 8'd28)  r = r - 8'd28;
        if (r >= 8'd14)  r = r - 8'd14;
        if (r >= 8'd7)   r = r - 8'd7;
        return r[2:0];
    endfunction

endpackage

`default_nettype wire

@@ src/weekday_alarm_clock.sv @@
// an accepted item is held in the command queue, then its result in the output register;
// the result is valid once that register is loaded and is taken when m_tready is high
// throughput: one item per cycle; the back end retires one command per cycle while
// m_tready allows; the 4-entry command queue lets input and output stall independently
// reset (rst_n, async, active low) clears time, sync, arm and queue state
// and the alarm registers; no clearing pass, items are taken right after reset
// top level: config registers, front end, command queue, back end; depends on wac_pkg
`default_nettype none

module weekday_alarm_clock
    import wac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // set_hour, set_minute, set_second, set_weekday
    input  wire logic [1:0]  s_tuser,   // req_type
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // fired, fired_action, now_hour, now_minute,
                                        // now_second, now_weekday, time_valid, zero pad
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cfg_wr;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        case (paddr[3:2])
            REG_ALARM_HOUR:   cfg_next.alarm_hour   = pwdata[4:0];
            REG_ALARM_MINUTE: cfg_next.alarm_minute = pwdata[5:0];
            REG_REPEAT_MASK:  cfg_next.repeat_mask  = pwdata[6:0];
            REG_ALARM_ACTION: cfg_next.alarm_action = pwdata[7:0];
            default:          cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_wr)
            cfg_reg <= cfg_next;
    end

    // read back
    always_comb
    begin
        case (paddr[3:2])
            REG_ALARM_HOUR:   prdata = {27'd0, cfg_reg.alarm_hour};
            REG_ALARM_MINUTE: prdata = {26'd0, cfg_reg.alarm_minute};
            REG_REPEAT_MASK:  prdata = {25'd0, cfg_reg.repeat_mask};
            REG_ALARM_ACTION: prdata = {24'd0, cfg_reg.alarm_action};
            default:          prdata = '0;
        endcase
    end

    wac_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    wac_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    wac_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

@@ src/wac_front.sv @@
// front end: accepts items and classifies them into commands
// depends on wac_pkg
`default_nettype none

module wac_front
    import wac_pkg::*;
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // set_hour, set_minute, set_second, set_weekday
    input  wire logic [1:0]  s_tuser,   // req_type
    input  wire logic        q_full,
    output logic             q_push,
    output cmd_t             q_cmd
);

    // accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // reduce the sync fields up front so the back end only loads them
    always_comb
    begin
        q_cmd.kind    = s_tuser;
        q_cmd.hour    = mod24(s_tdata[7:0]);
        q_cmd.minute  = mod60(s_tdata[15:8]);
        q_cmd.second  = mod60(s_tdata[23:16]);
        q_cmd.weekday = mod7(s_tdata[31:24]);
    end

endmodule

`default_nettype wire

@@ src/wac_fifo.sv @@
// short command queue between front and back end
// depends on wac_pkg
`default_nettype none

module wac_fifo
    import wac_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head_cmd
);

    cmd_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign full      = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

@@ src/wac_back.sv @@
// back end: time counters, alarm match and the output register
// depends on wac_pkg
`default_nettype none

module wac_back
    import wac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        q_not_empty,
    input  wire cmd_t        q_cmd,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // fired, fired_action, now_hour, now_minute,
                                        // now_second, now_weekday, time_valid, zero pad
);

    logic [MS_W-1:0] ms_reg, ms_next;
    logic [5:0]      sec_reg, sec_next;
    logic [5:0]      min_reg, min_next;
    logic [4:0]      hour_reg, hour_next;
    logic [2:0]      wd_reg, wd_next;
    logic            synced_reg, synced_next;
    logic            armed_reg, armed_next;
    logic            ftm_reg, ftm_next;
    logic            fire;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     out_data_reg, out_data_next;
    logic [4:0]      alarm_hour_red;
    logic [5:0]      alarm_min_red;

    // take the head command when the output register frees up
    assign q_pop = q_not_empty && (!out_valid_reg || m_tready);

    // alarm registers reduced before the compare
    assign alarm_hour_red = (cfg.alarm_hour >= 5'd24) ? cfg.alarm_hour - 5'd24
                                                      : cfg.alarm_hour;
    assign alarm_min_red  = (cfg.alarm_minute >= 6'd60) ? cfg.alarm_minute - 6'd60
                                                        : cfg.alarm_minute;

    // command execution
    always_comb
    begin
        ms_next     = ms_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        wd_next     = wd_reg;
        synced_next = synced_reg;
        armed_next  = armed_reg;
        ftm_next    = ftm_reg;
        fire        = 1'b0;
        case (q_cmd.kind)
            REQ_TICK:
            begin
                if (synced_reg)
                begin
                    // cascaded counters
                    if (ms_reg == MS_W'(TICKS_PER_SECOND - 1))
                    begin
                        ms_next = '0;
                        if (sec_reg == 6'd59)
                        begin
                            sec_next = 6'd0;
                            ftm_next = 1'b0;
                            if (min_reg == 6'd59)
                            begin
                                min_next = 6'd0;
                                if (hour_reg == 5'd23)
                                begin
                                    hour_next = 5'd0;
                                    wd_next   = (wd_reg == 3'd6) ? 3'd0 : wd_reg + 3'd1;
                                end
                                else
                                    hour_next = hour_reg + 5'd1;
                            end
                            else
                                min_next = min_reg + 6'd1;
                        end
                        else
                            sec_next = sec_reg + 6'd1;
                    end
                    else
                        ms_next = ms_reg + 1'b1;

                    // alarm match on the advanced time
                    if (armed_reg && !ftm_next && hour_next == alarm_hour_red &&
                        min_next == alarm_min_red &&
                        (cfg.repeat_mask == '0 || cfg.repeat_mask[wd_next]))
                    begin
                        fire     = 1'b1;
                        ftm_next = 1'b1;
                        if (cfg.repeat_mask == '0)
                            armed_next = 1'b0;
                    end
                end
            end
            REQ_SYNC:
            begin
                if (q_cmd.hour != hour_reg || q_cmd.minute != min_reg)
                    ftm_next = 1'b0;
                hour_next   = q_cmd.hour;
                min_next    = q_cmd.minute;
                sec_next    = q_cmd.second;
                wd_next     = q_cmd.weekday;
                ms_next     = '0;
                synced_next = 1'b1;
            end
            REQ_ARM:
                armed_next = 1'b1;
            REQ_CLEAR:
                armed_next = 1'b0;
            default:
                armed_next = armed_reg;
        endcase
    end

    // result packing and output register
    always_comb
    begin
        out_data_next = {2'b00, synced_next,
                         synced_next ? wd_next   : 3'd0,
                         synced_next ? sec_next  : 6'd0,
                         synced_next ? min_next  : 6'd0,
                         synced_next ? hour_next : 5'd0,
                         fire ? cfg.alarm_action : 8'd0,
                         fire};
        if (q_pop)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg        <= '0;
            sec_reg       <= '0;
            min_reg       <= '0;
            hour_reg      <= '0;
            wd_reg        <= '0;
            synced_reg    <= 1'b0;
            armed_reg     <= 1'b0;
            ftm_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                ms_reg     <= ms_next;
                sec_reg    <= sec_next;
                min_reg    <= min_next;
                hour_reg   <= hour_next;
                wd_reg     <= wd_next;
                synced_reg <= synced_next;
                armed_reg  <= armed_next;
                ftm_reg    <= ftm_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a firing needs a synced, armed clock
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && fire) |-> (armed_reg && synced_reg))
        else $error("alarm fired while disarmed or unsynced");

    // a firing blocks the rest of the minute
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && fire) |=> ftm_reg)
        else $error("fired flag not set after firing");

    // one-shot alarm disarms itself
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && fire && cfg.repeat_mask == '0) |=> !armed_reg)
        else $error("one-shot alarm still armed");

    // time counters stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (hour_reg < 5'd24) && (min_reg < 6'd60) && (sec_reg < 6'd60) && (wd_reg < 3'd7))
        else $error("time counter out of range");

endmodule

`default_nettype wire

@@ tb/wac_alarm_checker.sv @@
`timescale 1ns / 1ps
// checker for the weekday alarm clock: keeps its own copy of the clock state and alarm
// registers, predicts one reading per accepted item and compares the result stream; uses wac_pkg
module wac_alarm_checker
    import wac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream, watched only
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // set_hour, set_minute, set_second, set_weekday
    input  logic [1:0]  s_tuser,    // req_type
    // result stream, watched only
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // fired, fired_action, now_hour, now_minute,
                                    // now_second, now_weekday, time_valid, zero pad
    // config port, watched only
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding
);

    // one reading as packed on m_tdata, fired in bit 0
    typedef struct packed {
        logic       valid;
        logic [2:0] weekday;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [7:0] action;
        logic       fired;
    } reading_t;

    // alarm registers as last written
    logic [4:0] cfg_hour;
    logic [5:0] cfg_minute;
    logic [6:0] cfg_mask;
    logic [7:0] cfg_action;

    // predicted clock state
    logic [MS_W-1:0] ms_cnt;
    logic [5:0]      cur_second;
    logic [5:0]      cur_minute;
    logic [4:0]      cur_hour;
    logic [2:0]      cur_weekday;
    logic            synced;
    logic            armed;
    logic            minute_done;

    reading_t pending_readings[$];
    reading_t want_r;
    reading_t got_r;

    // advance the clock for one item and work out the reading it produces
    task automatic predict_reading(input logic [1:0] kind, input logic [31:0] data,
                                   output reading_t res);
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic       fire;
        fire = 1'b0;
        case (kind)
            REQ_TICK:
            begin
                if (synced)
                begin
                    // tick count carries into second, minute, hour, weekday
                    if (int'(ms_cnt) + 1 < TICKS_PER_SECOND)
                        ms_cnt = ms_cnt + 1'b1;
                    else
                    begin
                        ms_cnt = '0;
                        if (cur_second != 6'd59)
                            cur_second = cur_second + 1'b1;
                        else
                        begin
                            cur_second  = '0;
                            minute_done = 1'b0;
                            if (cur_minute != 6'd59)
                                cur_minute = cur_minute + 1'b1;
                            else
                            begin
                                cur_minute = '0;
                                if (cur_hour != 5'd23)
                                    cur_hour = cur_hour + 1'b1;
                                else
                                begin
                                    cur_hour    = '0;
                                    cur_weekday = (cur_weekday == 3'd6) ? 3'd0
                                                                        : cur_weekday + 1'b1;
                                end
                            end
                        end
                    end
                    // alarm match on the updated time
                    if (armed && !minute_done
                        && cur_hour == cfg_hour % 24 && cur_minute == cfg_minute % 60
                        && (cfg_mask == '0 || cfg_mask[cur_weekday]))
                    begin
                        fire        = 1'b1;
                        minute_done = 1'b1;
                        if (cfg_mask == '0)
                            armed = 1'b0;
                    end
                end
            end
            REQ_SYNC:
            begin
                new_hour   = 5'(data[7:0] % 24);
                new_minute = 6'(data[15:8] % 60);
                // a different hour or minute reopens the once-per-minute window
                if (new_hour != cur_hour || new_minute != cur_minute)
                    minute_done = 1'b0;
                cur_hour    = new_hour;
                cur_minute  = new_minute;
                cur_second  = 6'(data[23:16] % 60);
                cur_weekday = 3'(data[31:24] % 7);
                ms_cnt      = '0;
                synced      = 1'b1;
            end
            REQ_ARM:
                armed = 1'b1;
            default:
                armed = 1'b0;
        endcase

        res.fired   = fire;
        res.action  = fire ? cfg_action : 8'd0;
        res.hour    = synced ? cur_hour : 5'd0;
        res.minute  = synced ? cur_minute : 6'd0;
        res.second  = synced ? cur_second : 6'd0;
        res.weekday = synced ? cur_weekday : 3'd0;
        res.valid   = synced;
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // follow register writes, items in and readings out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_hour    = '0;
            cfg_minute  = '0;
            cfg_mask    = '0;
            cfg_action  = '0;
            ms_cnt      = '0;
            cur_second  = '0;
            cur_minute  = '0;
            cur_hour    = '0;
            cur_weekday = '0;
            synced      = 1'b0;
            armed       = 1'b0;
            minute_done = 1'b0;
            pending_readings.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            // register write
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_ALARM_HOUR:   cfg_hour   = pwdata[4:0];
                    REG_ALARM_MINUTE: cfg_minute = pwdata[5:0];
                    REG_REPEAT_MASK:  cfg_mask   = pwdata[6:0];
                    default:          cfg_action = pwdata[7:0];
                endcase
            end

            // accepted item
            if (s_tvalid && s_tready)
            begin
                predict_reading(s_tuser, s_tdata, want_r);
                pending_readings.push_back(want_r);
            end

            // accepted reading
            if (m_tvalid && m_tready)
            begin
                if (pending_readings.size() == 0)
                begin
                    $error("reading %h with no item pending", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want_r = pending_readings.pop_front();
                    got_r  = m_tdata[29:0];
                    compare_field("fired", want_r.fired, got_r.fired);
                    compare_field("fired_action", want_r.action, got_r.action);
                    compare_field("now_hour", want_r.hour, got_r.hour);
                    compare_field("now_minute", want_r.minute, got_r.minute);
                    compare_field("now_second", want_r.second, got_r.second);
                    compare_field("now_weekday", want_r.weekday, got_r.weekday);
                    compare_field("time_valid", want_r.valid, got_r.valid);
                    compare_field("zero pad", 0, m_tdata[31:30]);
                end
            end

            outstanding = pending_readings.size();
        end
    end

endmodule

@@ tb/tb_weekday_alarm_clock.sv @@
`timescale 1ns / 1ps
// top of the weekday alarm clock testbench: clock, reset, register writes and item stimulus
// depends on wac_pkg, weekday_alarm_clock and wac_alarm_checker
module tb_weekday_alarm_clock;
    import wac_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // set_hour, set_minute, set_second, set_weekday
    logic [1:0]  s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // fired, fired_action, now_hour, now_minute,
                            // now_second, now_weekday, time_valid, zero pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    int items_sent;
    int stall_cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    // alarm time as written, used to aim syncs at it
    int tgt_hour;
    int tgt_minute;

    weekday_alarm_clock u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    wac_alarm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("weekday_alarm_clock: mismatch");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [31:0] pack_time(input int hour, input int minute,
                                              input int second, input int weekday);
        return {weekday[7:0], second[7:0], minute[7:0], hour[7:0]};
    endfunction

    // some 8-bit value that reduces to base
    function automatic int alias_of(input int base, input int modulus);
        return base + modulus * $urandom_range(0, (255 - base) / modulus);
    endfunction

    // sync word landing on the alarm hour and minute
    function automatic logic [31:0] alarm_sync_word();
        return pack_time(alias_of(tgt_hour % 24, 24), alias_of(tgt_minute % 60, 60),
                         $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    // one item, called and returning at a falling edge
    task automatic send_item(input logic [1:0] kind, input logic [31:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        @(negedge clk);
    endtask

    // stop sending and wait for every reading to come back
    task automatic drain_readings();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
    endtask

    task automatic set_alarm(input int hour, input int minute, input int mask,
                             input logic [31:0] action);
        drain_readings();
        write_reg(REG_ALARM_HOUR, hour);
        write_reg(REG_ALARM_MINUTE, minute);
        write_reg(REG_REPEAT_MASK, mask);
        write_reg(REG_ALARM_ACTION, action);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        tgt_hour   = hour & 31;
        tgt_minute = minute & 63;
    endtask

    // random mix: mostly syncs onto the alarm time followed by arm and ticks,
    // the rest syncs elsewhere and plain noise
    task automatic run_random(input int budget);
        int         stop_at;
        int         pick;
        logic [1:0] kind;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                send_item(REQ_SYNC, alarm_sync_word());
                if ($urandom_range(0, 3) != 0)
                    send_item(REQ_ARM, $urandom());
                repeat ($urandom_range(1, 6))
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        send_item(REQ_TICK, $urandom());
                    else if (pick == 7)
                        send_item(REQ_SYNC, alarm_sync_word());
                    else if (pick == 8)
                        send_item(REQ_ARM, $urandom());
                    else
                        send_item(REQ_CLEAR, $urandom());
                end
            end
            else if (pick < 8)
            begin
                send_item(REQ_SYNC, $urandom());
                send_item(REQ_ARM, $urandom());
                repeat ($urandom_range(1, 4))
                    send_item(REQ_TICK, $urandom());
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    kind = 2'($urandom_range(0, 3));
                    send_item(kind, $urandom());
                end
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_TICK;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        items_sent  = 0;
        stall_cycles = 0;
        tx_idle_pct = 8;
        rx_idle_pct = 73;
        tgt_hour    = 0;
        tgt_minute  = 0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // out-of-range alarm 31:63 compares as 07:03, one-shot, widest action
        set_alarm(31, 63, 0, 255);

        // ticks before any sync do nothing; the arm before sync is undone by the clear
        send_item(REQ_TICK, 32'h0000_0000);
        send_item(REQ_ARM, 32'h0000_0000);
        send_item(REQ_TICK, 32'hFFFF_FFFF);
        send_item(REQ_CLEAR, 32'hFFFF_FFFF);
        // sync with every field at its top and bottom value
        send_item(REQ_SYNC, 32'hFFFF_FFFF);
        send_item(REQ_TICK, 32'h0000_0000);
        send_item(REQ_SYNC, 32'h0000_0000);
        // one-shot fires once and disarms
        send_item(REQ_ARM, 32'h0000_0000);
        send_item(REQ_SYNC, pack_time(7, 3, 0, 0));
        send_item(REQ_TICK, 32'h0000_0000);
        send_item(REQ_TICK, 32'h0000_0000);
        // rearmed in the same minute stays quiet
        send_item(REQ_ARM, 32'h0000_0000);
        send_item(REQ_TICK, 32'h0000_0000);
        // sync to the same hour and minute keeps the minute used up
        send_item(REQ_SYNC, pack_time(31, 63, 30, 7));
        send_item(REQ_TICK, 32'h0000_0000);
        // moving away and back reopens the minute
        send_item(REQ_SYNC, pack_time(6, 3, 0, 0));
        send_item(REQ_SYNC, pack_time(7, 3, 0, 0));
        send_item(REQ_TICK, 32'h0000_0000);
        // clear before a tick suppresses firing
        send_item(REQ_ARM, 32'h0000_0000);
        send_item(REQ_CLEAR, 32'h0000_0000);
        send_item(REQ_TICK, 32'h0000_0000);

        // phase 1: slow receiver, every weekday repeats
        tx_idle_pct = 8;
        rx_idle_pct = 73;
        set_alarm(23, 59, 127, $urandom_range(0, 255));
        run_random(200);

        // phase 2: slow sender, one-shot at midnight, with a full pause midway
        tx_idle_pct = 73;
        rx_idle_pct = 8;
        set_alarm(0, 0, 0, 0);
        run_random(100);
        drain_readings();
        run_random(100);

        // phase 3: no idling; a full day rollover into a weekday-masked alarm
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_alarm(0, 0, $urandom_range(0, 127) | 1, $urandom());
        send_item(REQ_SYNC, pack_time(23, 59, 59, 6));
        send_item(REQ_ARM, $urandom());
        repeat (TICKS_PER_SECOND + 2)
            send_item(REQ_TICK, $urandom());
        run_random(125);

        drain_readings();
        if (fail_count == 0)
            $display("weekday_alarm_clock: match");
        else
            $display("weekday_alarm_clock: mismatch");
        $finish;
    end

endmodule
